// ----- sv/cttr_pkg.sv -----
`default_nettype none
package cttr_pkg;

   // Genetic-code table geometry.
   localparam int TABLE_DEPTH = 65;
   localparam int ADDR_W      = 7;
   localparam logic [ADDR_W-1:0] AMBIG_ENTRY = 7'd64;

   // Word kinds on the request channel.
   localparam logic ACTION_BASE  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // Number of codon jobs the queue between front and back can hold.
   localparam int QUEUE_DEPTH = 4;
   localparam int QCOUNT_W    = 3;

   // Base codes: two-bit nucleotide value, with bit 2 flagging a foreign character.
   localparam logic [2:0] BASE_A     = 3'd0;
   localparam logic [2:0] BASE_C     = 3'd1;
   localparam logic [2:0] BASE_G     = 3'd2;
   localparam logic [2:0] BASE_T     = 3'd3;
   localparam logic [2:0] BASE_OTHER = 3'd4;

   // Control side of the table memory port.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } cttr_mem_ctl_type;

   function automatic logic [2:0] base_value(input logic [7:0] c);
      logic [2:0] v;
      unique case (c) inside
         8'h41, 8'h61:               v = BASE_A;
         8'h43, 8'h63:               v = BASE_C;
         8'h47, 8'h67:               v = BASE_G;
         8'h54, 8'h74, 8'h55, 8'h75: v = BASE_T;
         default:                    v = BASE_OTHER;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- sv/cttr_ram.sv -----
`default_nettype none
module cttr_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 65
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- sv/cttr_front.sv -----
`default_nettype none
module cttr_front
   import cttr_pkg::*;
#(
   parameter int MAX_CODE_CHARS = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_action,
   input  wire logic [7:0]                  req_base_char,
   input  wire logic                        req_seq_end,
   input  wire logic [6:0]                  req_entry_index,
   input  wire logic [1:0]                  req_entry_length,
   input  wire logic [23:0]                 req_entry_chars,
   input  wire logic [QCOUNT_W-1:0]         queue_count,
   output cttr_mem_ctl_type                 mem_ctl,
   output logic [8*MAX_CODE_CHARS+1:0]      mem_wdata,
   output logic                             lookup_valid,
   output logic                             lookup_seq_end
);

   localparam logic [1:0] MAX_LEN = 2'(MAX_CODE_CHARS);

   logic [1:0] phase_ff, phase_in;
   logic [5:0] acc_ff, acc_in;
   logic       amb_ff, amb_in;
   logic       lookup_valid_ff, lookup_valid_in;
   logic       seq_end_ff, seq_end_in;

   logic                  accept;
   logic [2:0]            bv;
   logic [1:0]            phase_next;
   logic [5:0]            acc_next;
   logic                  amb_next;
   logic                  codon_done;
   logic [1:0]            len_sat;
   logic [QCOUNT_W-1:0]   pending;

   // Credit check: queued jobs plus the lookup still in flight.
   assign pending   = queue_count + QCOUNT_W'(lookup_valid_ff);
   assign req_stall = (pending >= QCOUNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid & ~req_stall;

   assign bv         = base_value(req_base_char);
   assign amb_next   = amb_ff | bv[2];
   assign acc_next   = {acc_ff[3:0], (bv[2] ? 2'b00 : bv[1:0])};
   assign phase_next = phase_ff + 2'd1;
   assign codon_done = accept & (req_action == ACTION_BASE) & (phase_next == 2'd3);
   assign len_sat    = (req_entry_length > MAX_LEN) ? MAX_LEN : req_entry_length;

   always_comb begin
      phase_in        = phase_ff;
      acc_in          = acc_ff;
      amb_in          = amb_ff;
      lookup_valid_in = codon_done;
      seq_end_in      = seq_end_ff;
      if (accept && (req_action == ACTION_BASE)) begin
         if (codon_done || req_seq_end) begin
            phase_in = 2'd0;
            acc_in   = 6'd0;
            amb_in   = 1'b0;
         end else begin
            phase_in = phase_next;
            acc_in   = acc_next;
            amb_in   = amb_next;
         end
      end
      if (codon_done) begin
         seq_end_in = req_seq_end;
      end
   end

   always_comb begin
      mem_ctl.we    = accept & (req_action == ACTION_WRITE) &
                      (req_entry_index <= AMBIG_ENTRY);
      mem_ctl.waddr = req_entry_index;
      mem_ctl.re    = codon_done;
      mem_ctl.raddr = amb_next ? AMBIG_ENTRY : {1'b0, acc_next};
   end

   assign mem_wdata = {req_entry_chars[8*MAX_CODE_CHARS-1:0], len_sat};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= 2'd0;
         acc_ff          <= 6'd0;
         amb_ff          <= 1'b0;
         lookup_valid_ff <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         acc_ff          <= acc_in;
         amb_ff          <= amb_in;
         lookup_valid_ff <= lookup_valid_in;
      end
      seq_end_ff <= seq_end_in;
   end

   assign lookup_valid   = lookup_valid_ff;
   assign lookup_seq_end = seq_end_ff;

endmodule
`default_nettype wire

// ----- sv/cttr_queue.sv -----
`default_nettype none
module cttr_queue
   import cttr_pkg::*;
#(
   parameter int WIDTH = 27
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire logic [WIDTH-1:0]    push_data,
   input  wire logic                pop,
   output logic                     not_empty,
   output logic [WIDTH-1:0]         head_data,
   output logic [QCOUNT_W-1:0]      count
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   // The front never pushes into a full queue (credit check), and the back
   // only pops when not empty.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCOUNT_W'(push) - QCOUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
`default_nettype wire

// ----- sv/cttr_back.sv -----
`default_nettype none
module cttr_back #(
   parameter int MAX_CODE_CHARS = 3
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         job_ready,
   input  wire logic [8*MAX_CODE_CHARS+2:0]  job_data,
   output logic                              job_pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [7:0]                        rsp_amino_char,
   output logic                              rsp_codon_last,
   output logic                              rsp_sequence_last
);

   localparam int CHARS_W = 8 * MAX_CODE_CHARS;

   logic               job_valid_ff, job_valid_in;
   logic [CHARS_W-1:0] chars_ff, chars_in;
   logic [1:0]         len_ff, len_in;
   logic               seq_end_ff, seq_end_in;
   logic [1:0]         k_ff, k_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         char_ff, char_in;
   logic               codon_last_ff, codon_last_in;
   logic               seq_last_ff, seq_last_in;

   logic out_free;
   logic emit;
   logic last_char;
   logic job_done;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign last_char = ((k_ff + 2'd1) == len_ff);
   assign emit      = job_valid_ff & (len_ff != 2'd0) & out_free;
   // An empty entry retires without emitting anything.
   assign job_done  = job_valid_ff & ((len_ff == 2'd0) | (emit & last_char));
   assign job_pop   = job_ready & (~job_valid_ff | job_done);

   always_comb begin
      job_valid_in = job_valid_ff;
      chars_in     = chars_ff;
      len_in       = len_ff;
      seq_end_in   = seq_end_ff;
      k_in         = k_ff;
      if (job_pop) begin
         job_valid_in = 1'b1;
         {seq_end_in, chars_in, len_in} = job_data;
         k_in = 2'd0;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         k_in = k_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      char_in       = char_ff;
      codon_last_in = codon_last_ff;
      seq_last_in   = seq_last_ff;
      if (out_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         char_in       = chars_ff[8*k_ff +: 8];
         codon_last_in = last_char;
         seq_last_in   = seq_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chars_ff      <= chars_in;
      len_ff        <= len_in;
      seq_end_ff    <= seq_end_in;
      k_ff          <= k_in;
      char_ff       <= char_in;
      codon_last_ff <= codon_last_in;
      seq_last_ff   <= seq_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_amino_char    = char_ff;
   assign rsp_codon_last    = codon_last_ff;
   assign rsp_sequence_last = seq_last_ff;

endmodule
`default_nettype wire

// ----- sv/codon_to_amino_translator.sv -----
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   action, base_char, seq_end, entry_index,
//                                            entry_length, entry_chars
// rsp_      out        rsp_valid/rsp_stall   amino_char, codon_last, sequence_last
//
// One request word is taken per cycle while the job queue has room. One response
// word leaves per cycle while rsp_stall is low; a codon with an entry of n
// characters yields n response words, and an empty entry yields none. The first
// character of a codon passes from the completing base through the table read,
// queue write, job register and output register. Reset is synchronous and clears
// control state only; the table is undefined until written. rsp_stall holds the
// output register and backs up the queue, which then raises req_stall.
`default_nettype none
module codon_to_amino_translator
   import cttr_pkg::*;
#(
   parameter int MAX_CODE_CHARS = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_base_char,
   input  wire logic        req_seq_end,
   input  wire logic [6:0]  req_entry_index,
   input  wire logic [1:0]  req_entry_length,
   input  wire logic [23:0] req_entry_chars,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_amino_char,
   output logic             rsp_codon_last,
   output logic             rsp_sequence_last
);

   // A table entry holds the saturated length in its low two bits and the
   // characters above it, first character in the lowest byte.
   localparam int ENTRY_W = 8 * MAX_CODE_CHARS + 2;
   localparam int JOB_W   = ENTRY_W + 1;

   cttr_mem_ctl_type     mem_ctl;
   logic [ENTRY_W-1:0]   mem_wdata;
   logic [ENTRY_W-1:0]   mem_rdata;
   logic                 lookup_valid;
   logic                 lookup_seq_end;
   logic [QCOUNT_W-1:0]  queue_count;
   logic                 queue_not_empty;
   logic [JOB_W-1:0]     queue_head;
   logic                 job_pop;

   // Front end: takes request words, tracks the triplet in progress, writes the
   // table and launches one table read per completed codon.
   cttr_front #(
      .MAX_CODE_CHARS (MAX_CODE_CHARS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_base_char    (req_base_char),
      .req_seq_end      (req_seq_end),
      .req_entry_index  (req_entry_index),
      .req_entry_length (req_entry_length),
      .req_entry_chars  (req_entry_chars),
      .queue_count      (queue_count),
      .mem_ctl          (mem_ctl),
      .mem_wdata        (mem_wdata),
      .lookup_valid     (lookup_valid),
      .lookup_seq_end   (lookup_seq_end)
   );

   // Genetic-code table, 64 codons plus the ambiguous entry.
   cttr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (mem_ctl.we),
      .waddr (mem_ctl.waddr),
      .wdata (mem_wdata),
      .re    (mem_ctl.re),
      .raddr (mem_ctl.raddr),
      .rdata (mem_rdata)
   );

   // Looked-up entries wait here together with their end-of-sequence flag.
   cttr_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (lookup_valid),
      .push_data ({lookup_seq_end, mem_rdata}),
      .pop       (job_pop),
      .not_empty (queue_not_empty),
      .head_data (queue_head),
      .count     (queue_count)
   );

   // Back end: expands each entry into its characters, one per cycle unless rsp_stall holds the output.
   cttr_back #(
      .MAX_CODE_CHARS (MAX_CODE_CHARS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_ready         (queue_not_empty),
      .job_data          (queue_head),
      .job_pop           (job_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_amino_char    (rsp_amino_char),
      .rsp_codon_last    (rsp_codon_last),
      .rsp_sequence_last (rsp_sequence_last)
   );

endmodule
`default_nettype wire

// ----- sv/cttr_checker.sv -----
`default_nettype none
module cttr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_amino_char,
   input wire logic        rsp_codon_last,
   input wire logic        rsp_sequence_last
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_amino_char) &&
      $stable(rsp_codon_last) && $stable(rsp_sequence_last))
      else $error("stalled response word changed");

   // The characters of one codon leave back to back.
   a_codon_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_codon_last |=> rsp_valid)
      else $error("gap inside a codon's characters");

   // Every character of one codon carries the same end-of-sequence flag.
   a_codon_seq_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_codon_last |=>
      rsp_sequence_last == $past(rsp_sequence_last))
      else $error("sequence_last changed inside a codon");

   // Nothing is presented in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind codon_to_amino_translator cttr_checker u_cttr_checker (.*);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import cttr_pkg::*;

   // No word may stay stuck this long. The slowest legal pace is the longest sender
   // gap followed by three amino words, each held by the longest response stall.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 130;
   // After the last amino word, keep watching for any stray output.
   localparam int DRAIN_CYCLES   = 16;
   // The nucleotide letters, one per byte, used to build well-formed codons.
   localparam logic [79:0] NUCLEOTIDES = "ACGTUacgtu";

   // One request word, in the same order as the request ports.
   typedef struct packed {
      logic        action;
      logic [7:0]  base_char;
      logic        seq_end;
      logic [6:0]  entry_index;
      logic [1:0]  entry_length;
      logic [23:0] entry_chars;
   } req_word_type;

   // One response word.
   typedef struct packed {
      logic [7:0] amino_char;
      logic       codon_last;
      logic       sequence_last;
   } amino_word_type;

   // A row of the directed table. When known_answer is set, the amino words
   // are written into the row itself, first character in the low byte.
   typedef struct {
      req_word_type word;
      bit           known_answer;
      int unsigned  n_chars;
      logic [23:0]  chars;
   } directed_row_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_action       = ACTION_BASE;
   logic [7:0]  req_base_char    = 8'h00;
   logic        req_seq_end      = 1'b0;
   logic [6:0]  req_entry_index  = 7'd0;
   logic [1:0]  req_entry_length = 2'd0;
   logic [23:0] req_entry_chars  = 24'd0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_amino_char;
   logic        rsp_codon_last;
   logic        rsp_sequence_last;

   codon_to_amino_translator i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_base_char     (req_base_char),
      .req_seq_end       (req_seq_end),
      .req_entry_index   (req_entry_index),
      .req_entry_length  (req_entry_length),
      .req_entry_chars   (req_entry_chars),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_amino_char    (rsp_amino_char),
      .rsp_codon_last    (rsp_codon_last),
      .rsp_sequence_last (rsp_sequence_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Predicted state of the translator: the genetic-code table as loaded by
   // write words, and the codon being assembled from base words.
   logic [25:0]     genetic_code [TABLE_DEPTH];
   logic [1:0]      codon_phase     = 2'd0;
   logic [5:0]      codon_value     = 6'd0;
   logic            codon_ambiguous = 1'b0;
   amino_word_type  amino_expected [$];

   int unsigned  mismatch_count = 0;
   int unsigned  amino_checked  = 0;
   int unsigned  writes_sent    = 0;
   int unsigned  bases_sent     = 0;
   int unsigned  idle_cycles    = 0;
   int unsigned  stall_left     = 0;
   // While set, neither side inserts gaps, so the block runs at full rate.
   bit           quiet_stretch  = 1'b0;

   // Folding bit 5 away turns lower case into upper case. No other byte
   // lands on one of the five letters, so every other value is foreign.
   function automatic logic [2:0] nucleotide_code(input logic [7:0] c);
      logic [7:0] upper;
      upper = c & 8'hDF;
      unique case (upper) inside
         "A":      return BASE_A;
         "C":      return BASE_C;
         "G":      return BASE_G;
         "T", "U": return BASE_T;
         default:  return BASE_OTHER;
      endcase
   endfunction

   // Applies one accepted request word to the predicted state. When
   // queue_results is set, the amino words it causes join the expected queue.
   function automatic void translate_word(input req_word_type w, input bit queue_results);
      logic [2:0]     code;
      logic [25:0]    entry;
      int             n;
      int             k;
      amino_word_type a;
      if (w.action == ACTION_WRITE) begin
         // Writes beyond the ambiguous entry fall outside the table and are
         // dropped. The two-bit length cannot exceed three characters.
         if (w.entry_index <= AMBIG_ENTRY) begin
            genetic_code[w.entry_index] = {w.entry_chars, w.entry_length};
         end
         return;
      end
      code = nucleotide_code(w.base_char);
      // A foreign character marks the codon as ambiguous; its low bits are
      // zero, so it shifts a zero digit into the codon value.
      if (code == BASE_OTHER) begin
         codon_ambiguous = 1'b1;
      end
      codon_value = {codon_value[3:0], code[1:0]};
      codon_phase = codon_phase + 2'd1;
      if (codon_phase == 2'd3) begin
         entry = genetic_code[codon_ambiguous ? AMBIG_ENTRY : {1'b0, codon_value}];
         n = int'(entry[1:0]);
         for (k = 0; k < n; k++) begin
            a.amino_char    = entry[2 + 8 * k +: 8];
            a.codon_last    = (k == n - 1);
            a.sequence_last = w.seq_end;
            if (queue_results) begin
               amino_expected.push_back(a);
            end
         end
      end
      // A completed codon, or a sequence end in the middle of one, starts
      // the next codon from scratch.
      if (codon_phase == 2'd3 || w.seq_end) begin
         codon_phase     = 2'd0;
         codon_value     = 6'd0;
         codon_ambiguous = 1'b0;
      end
   endfunction

   function automatic directed_row_type write_row(input logic [6:0] idx, input logic [1:0] len,
                                                  input logic [23:0] chars, input logic se);
      directed_row_type r;
      r.word = '{action: ACTION_WRITE, base_char: 8'h41, seq_end: se, entry_index: idx,
                 entry_length: len, entry_chars: chars};
      r.known_answer = 1'b1;
      r.n_chars      = 0;
      r.chars        = 24'd0;
      return r;
   endfunction

   function automatic directed_row_type base_row(input logic [7:0] ch, input logic se,
                                                 input bit known, input int unsigned n,
                                                 input logic [23:0] chars);
      directed_row_type r;
      r.word = '{action: ACTION_BASE, base_char: ch, seq_end: se, entry_index: 7'($urandom),
                 entry_length: 2'($urandom), entry_chars: 24'($urandom)};
      r.known_answer = known;
      r.n_chars      = n;
      r.chars        = chars;
      return r;
   endfunction

   // Random word: mostly clean nucleotides, some foreign bytes, the odd
   // sequence end, and table rewrites now and then, some of them beyond
   // the table.
   function automatic req_word_type random_word();
      req_word_type w;
      int           pick;
      pick = $urandom_range(0, 9);
      w.action       = ($urandom_range(0, 9) == 0) ? ACTION_WRITE : ACTION_BASE;
      w.base_char    = ($urandom_range(0, 6) == 0) ? 8'($urandom) : NUCLEOTIDES[8 * pick +: 8];
      w.seq_end      = ($urandom_range(0, 11) == 0);
      w.entry_index  = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(65, 127))
                                                   : 7'($urandom_range(0, 64));
      w.entry_length = 2'($urandom);
      w.entry_chars  = 24'($urandom);
      return w;
   endfunction

   // Presents one word and returns at the edge where it is taken. Valid is
   // only lowered when a gap is drawn, so it never drops and rises in one step.
   task automatic send_word(input req_word_type w);
      int unsigned gap;
      gap = quiet_stretch ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_action, req_base_char, req_seq_end, req_entry_index, req_entry_length,
       req_entry_chars} <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (w.action == ACTION_WRITE) begin
         writes_sent++;
      end else begin
         bases_sent++;
      end
   endtask

   // Stops sending until every predicted amino word has come out.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (amino_expected.size() != 0) @(posedge clock);
   endtask

   // Response side: checks every word that leaves the block against the
   // oldest prediction, then draws how long to hold off the next one.
   always @(posedge clock) begin : rsp_side
      amino_word_type seen;
      amino_word_type want;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_amino_char, rsp_codon_last, rsp_sequence_last};
            if (amino_expected.size() == 0) begin
               mismatch_count++;
               $display("%0t: amino word %h/%b/%b arrived with none predicted",
                        $time, seen.amino_char, seen.codon_last, seen.sequence_last);
            end else begin
               want = amino_expected.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  $display("%0t: amino_char/codon_last/sequence_last expected %h/%b/%b",
                           $time, want.amino_char, want.codon_last, want.sequence_last);
                  $display("%0t:    got %h/%b/%b",
                           $time, seen.amino_char, seen.codon_last, seen.sequence_last);
               end
            end
            amino_checked++;
            stall_left = quiet_stretch ? 0 : $urandom_range(0, 4);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // The watchdog ends a run in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles, %0d amino words still awaited",
                  $time, idle_cycles, amino_expected.size());
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      directed_row_type rows [$];
      req_word_type     w;
      int               i;
      int               k;

      // Directed table. Entries are loaded before any codon reads them; the
      // table starts out undefined, so no codon ever touches an unwritten one.
      // Full-length entry, and a one-letter entry with junk in the unused bytes.
      rows.push_back(write_row(7'd0, 2'd3, 24'h73794C, 1'b0));
      rows.push_back(write_row(7'd63, 2'd1, 24'hFFFF46, 1'b0));
      // The ambiguous entry with every character bit set.
      rows.push_back(write_row(AMBIG_ENTRY, 2'd3, 24'hFFFFFF, 1'b0));
      // An empty entry, and one whose first character is a zero byte.
      rows.push_back(write_row(7'd27, 2'd0, 24'h2A2A2A, 1'b0));
      rows.push_back(write_row(7'd36, 2'd2, 24'h004100, 1'b0));
      // A write past the table is dropped; it would alias entry 63 if the
      // index were cut to six bits.
      rows.push_back(write_row(7'd127, 2'd3, 24'h000000, 1'b1));
      // Codon 0 from mixed case emits all three characters.
      rows.push_back(base_row("A", 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(base_row("a", 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(base_row("A", 1'b0, 1'b1, 3, 24'h73794C));
      // Codon 63 spelled with U and T, completed on the sequence end.
      rows.push_back(base_row("T", 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(base_row("u", 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(base_row("t", 1'b1, 1'b1, 1, 24'h000046));
      // A codon whose entry is empty emits nothing at all.
      rows.push_back(base_row("C", 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(base_row("g", 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(base_row("U", 1'b0, 1'b1, 0, 24'd0));
      // The zero byte goes out as a character; left to the predictor.
      rows.push_back(base_row("g", 1'b0, 1'b0, 0, 24'd0));
      rows.push_back(base_row("C", 1'b0, 1'b0, 0, 24'd0));
      rows.push_back(base_row("a", 1'b0, 1'b0, 0, 24'd0));
      // Foreign bytes at both extremes select the ambiguous entry.
      rows.push_back(base_row(8'h00, 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(base_row("A", 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(base_row(8'hFF, 1'b0, 1'b1, 3, 24'hFFFFFF));
      // A sequence end on the second base throws the partial codon away.
      rows.push_back(base_row("A", 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(base_row("C", 1'b1, 1'b1, 0, 24'd0));
      // A table write in mid codon leaves the codon alone, and its seq_end
      // bit is ignored; the completed codon sees the new entry.
      rows.push_back(base_row("T", 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(write_row(7'd63, 2'd2, 24'h006850, 1'b1));
      rows.push_back(base_row("T", 1'b0, 1'b1, 0, 24'd0));
      rows.push_back(base_row("T", 1'b0, 1'b1, 2, 24'h006850));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < rows.size(); i++) begin
         send_word(rows[i].word);
         translate_word(rows[i].word, !rows[i].known_answer);
         if (rows[i].known_answer) begin
            for (k = 0; k < rows[i].n_chars; k++) begin
               amino_expected.push_back('{rows[i].chars[8 * k +: 8], k == rows[i].n_chars - 1,
                                          rows[i].word.seq_end});
            end
         end
      end
      hold_until_drained();

      // Load every entry with random content so that any codon may follow.
      for (i = 0; i < TABLE_DEPTH; i++) begin
         w = random_word();
         w.action      = ACTION_WRITE;
         w.entry_index = 7'(i);
         send_word(w);
         translate_word(w, 1'b1);
      end

      // Random traffic, with a stretch at full rate every so often and one
      // pause in the middle until the block has emptied.
      for (i = 0; i < RANDOM_WORDS; i++) begin
         quiet_stretch = ((i % 48) >= 36);
         if (i == RANDOM_WORDS / 2) begin
            hold_until_drained();
         end
         w = random_word();
         send_word(w);
         translate_word(w, 1'b1);
      end
      quiet_stretch = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (amino_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words (%0d table writes, %0d bases)",
               writes_sent + bases_sent, writes_sent, bases_sent);
      $display("and checked %0d amino words.", amino_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
